[design/pts_pkg.sv]
package pts_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH     = 16;
   localparam int PRIORITY_LEVELS = 4;
   localparam int IDX_W           = $clog2(TABLE_DEPTH);
   localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);

   // Field widths of the request and response transfers.
   localparam int ACTION_W = 2;
   localparam int TIME_W   = 32;
   localparam int DUE_W    = TIME_W + 1;
   localparam int ID_W     = 16;
   localparam int LEVEL_W  = 2;

   // Priority level of plain timer tasks.
   localparam logic [LEVEL_W-1:0] TIMER_LEVEL = '0;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic step;
      logic update;
      logic load_rsp;
   } pts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip_scan;
      logic scan_last;
   } pts_stat_type;

endpackage

[design/pts_ctrl.sv]
module pts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pts_pkg::pts_stat_type stat,
   output pts_pkg::pts_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.skip_scan) begin
               state_in = S_UPDATE;
            end else begin
               cmd.step = 1'b1;
               if (stat.scan_last) begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/pts_datapath.sv]
module pts_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pts_pkg::ACTION_W-1:0]       req_action,
   input  logic [pts_pkg::TIME_W-1:0]         req_now_ms,
   input  logic [pts_pkg::ID_W-1:0]           req_task_id,
   input  logic [pts_pkg::LEVEL_W-1:0]        req_task_priority,
   input  logic [pts_pkg::TIME_W-1:0]         req_wait_ms,
   input  logic                               req_repeats,
   input  pts_pkg::pts_cmd_type               cmd,
   output pts_pkg::pts_stat_type              stat,
   output logic                               rsp_found,
   output logic [pts_pkg::ID_W-1:0]           rsp_chosen_id,
   output logic                               rsp_pending,
   output logic                               rsp_status
);

   // Task table, kept in insertion order. Entries at or above the count are
   // never read before they are written.
   logic [pts_pkg::TIME_W-1:0]  start_ff [pts_pkg::TABLE_DEPTH];
   logic [pts_pkg::TIME_W-1:0]  delay_ff [pts_pkg::TABLE_DEPTH];
   logic [pts_pkg::ID_W-1:0]    ident_ff [pts_pkg::TABLE_DEPTH];
   logic [pts_pkg::LEVEL_W-1:0] level_ff [pts_pkg::TABLE_DEPTH];
   logic                        rep_ff   [pts_pkg::TABLE_DEPTH];

   logic [pts_pkg::CNT_W-1:0]   count_ff, count_in;

   // Captured request.
   logic [pts_pkg::ACTION_W-1:0] act_ff, act_in;
   logic [pts_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [pts_pkg::ID_W-1:0]     id_ff, id_in;
   logic [pts_pkg::LEVEL_W-1:0]  prio_ff, prio_in;
   logic [pts_pkg::TIME_W-1:0]   new_delay_ff, new_delay_in;
   logic                         new_rep_ff, new_rep_in;

   // Scan position and search trackers.
   logic [pts_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [pts_pkg::LEVEL_W-1:0]  max_level_ff, max_level_in;
   logic [pts_pkg::DUE_W-1:0]    min_due_ff, min_due_in;
   logic                         have_due_ff, have_due_in;
   logic                         have_ff, have_in;
   logic [pts_pkg::IDX_W-1:0]    pick_ff, pick_in;
   logic [pts_pkg::ID_W-1:0]     pick_id_ff, pick_id_in;
   logic                         pick_rep_ff, pick_rep_in;
   logic                         pend_ff, pend_in;
   logic                         status_ff, status_in;

   // Response register.
   logic                         found_ff, found_in;
   logic [pts_pkg::ID_W-1:0]     chosen_ff, chosen_in;
   logic                         pending_ff, pending_in;
   logic                         rstat_ff, rstat_in;

   logic [pts_pkg::TIME_W-1:0]   cur_start;
   logic [pts_pkg::TIME_W-1:0]   cur_delay;
   logic [pts_pkg::ID_W-1:0]     cur_ident;
   logic [pts_pkg::LEVEL_W-1:0]  cur_level;
   logic                         cur_rep;
   logic [pts_pkg::DUE_W-1:0]    cur_due;
   logic                         due_ok;
   logic                         full;
   logic                         tbl_remove;
   logic                         tbl_restart;
   logic                         tbl_append;

   assign cur_start = start_ff[idx_ff];
   assign cur_delay = delay_ff[idx_ff];
   assign cur_ident = ident_ff[idx_ff];
   assign cur_level = level_ff[idx_ff];
   assign cur_rep   = rep_ff[idx_ff];
   assign cur_due   = {1'b0, cur_start} + {1'b0, cur_delay};
   assign due_ok    = (cur_due <= {1'b0, now_ff});

   assign full = (count_ff == pts_pkg::CNT_W'(pts_pkg::TABLE_DEPTH));

   assign stat.skip_scan = (act_ff == pts_pkg::ACT_ADD) || (count_ff == '0);
   assign stat.scan_last =
      ((pts_pkg::CNT_W'(idx_ff) + pts_pkg::CNT_W'(1)) == count_ff);

   assign tbl_remove  = cmd.update && have_ff &&
                        (((act_ff == pts_pkg::ACT_SELECT) && !pick_rep_ff) ||
                         (act_ff == pts_pkg::ACT_CANCEL));
   assign tbl_restart = cmd.update && have_ff && pick_rep_ff &&
                        (act_ff == pts_pkg::ACT_SELECT);
   assign tbl_append  = cmd.update && !full && (act_ff == pts_pkg::ACT_ADD);

   always_comb begin
      act_in       = act_ff;
      now_in       = now_ff;
      id_in        = id_ff;
      prio_in      = prio_ff;
      new_delay_in = new_delay_ff;
      new_rep_in   = new_rep_ff;
      idx_in       = idx_ff;
      max_level_in = max_level_ff;
      min_due_in   = min_due_ff;
      have_due_in  = have_due_ff;
      have_in      = have_ff;
      pick_in      = pick_ff;
      pick_id_in   = pick_id_ff;
      pick_rep_in  = pick_rep_ff;
      pend_in      = pend_ff;
      status_in    = status_ff;
      count_in     = count_ff;

      if (cmd.load_req) begin
         act_in       = req_action;
         now_in       = req_now_ms;
         id_in        = req_task_id;
         // Levels beyond the supported range saturate at the top level.
         if (32'(req_task_priority) >= pts_pkg::PRIORITY_LEVELS) begin
            prio_in = pts_pkg::LEVEL_W'(pts_pkg::PRIORITY_LEVELS - 1);
         end else begin
            prio_in = req_task_priority;
         end
         new_delay_in = req_wait_ms;
         new_rep_in   = req_repeats;
         idx_in       = '0;
         max_level_in = pts_pkg::TIMER_LEVEL;
         min_due_in   = '0;
         have_due_in  = 1'b0;
         have_in      = 1'b0;
         pick_in      = '0;
         pick_id_in   = '0;
         pick_rep_in  = 1'b0;
         pend_in      = 1'b0;
      end else if (cmd.step) begin
         idx_in = idx_ff + pts_pkg::IDX_W'(1);
         case (act_ff)
            pts_pkg::ACT_SELECT: begin
               if (cur_level > max_level_ff) begin
                  max_level_in = cur_level;
                  have_in      = 1'b1;
                  pick_in      = idx_ff;
                  pick_id_in   = cur_ident;
                  pick_rep_in  = cur_rep;
               end else if ((max_level_ff == pts_pkg::TIMER_LEVEL) && due_ok &&
                            (!have_due_ff || (cur_due < min_due_ff))) begin
                  min_due_in  = cur_due;
                  have_due_in = 1'b1;
                  have_in     = 1'b1;
                  pick_in     = idx_ff;
                  pick_id_in  = cur_ident;
                  pick_rep_in = cur_rep;
               end
            end
            pts_pkg::ACT_CANCEL: begin
               if (!have_ff && (cur_ident == id_ff)) begin
                  have_in = 1'b1;
                  pick_in = idx_ff;
               end
            end
            pts_pkg::ACT_QUERY: begin
               if (!cur_rep) begin
                  pend_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.update) begin
         status_in = full && (act_ff == pts_pkg::ACT_ADD);
         if (tbl_remove) begin
            count_in = count_ff - pts_pkg::CNT_W'(1);
         end else if (tbl_append) begin
            count_in = count_ff + pts_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      found_in   = found_ff;
      chosen_in  = chosen_ff;
      pending_in = pending_ff;
      rstat_in   = rstat_ff;
      if (cmd.load_rsp) begin
         found_in   = have_ff && ((act_ff == pts_pkg::ACT_SELECT) ||
                                  (act_ff == pts_pkg::ACT_CANCEL));
         chosen_in  = (have_ff && (act_ff == pts_pkg::ACT_SELECT)) ? pick_id_ff : '0;
         pending_in = pend_ff && (act_ff == pts_pkg::ACT_QUERY);
         rstat_in   = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      now_ff       <= now_in;
      id_ff        <= id_in;
      prio_ff      <= prio_in;
      new_delay_ff <= new_delay_in;
      new_rep_ff   <= new_rep_in;
      idx_ff       <= idx_in;
      max_level_ff <= max_level_in;
      min_due_ff   <= min_due_in;
      have_due_ff  <= have_due_in;
      have_ff      <= have_in;
      pick_ff      <= pick_in;
      pick_id_ff   <= pick_id_in;
      pick_rep_ff  <= pick_rep_in;
      pend_ff      <= pend_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      chosen_ff    <= chosen_in;
      pending_ff   <= pending_in;
      rstat_ff     <= rstat_in;
   end

   // Table writes: removal closes the gap by moving later entries up one place.
   always_ff @(posedge clock) begin
      if (tbl_remove) begin
         for (int k = 0; k < pts_pkg::TABLE_DEPTH - 1; k++) begin
            if (k >= int'(pick_ff)) begin
               start_ff[k] <= start_ff[k+1];
               delay_ff[k] <= delay_ff[k+1];
               ident_ff[k] <= ident_ff[k+1];
               level_ff[k] <= level_ff[k+1];
               rep_ff[k]   <= rep_ff[k+1];
            end
         end
      end
      if (tbl_restart) begin
         start_ff[pick_ff] <= now_ff;
      end
      if (tbl_append) begin
         start_ff[count_ff[pts_pkg::IDX_W-1:0]] <= now_ff;
         delay_ff[count_ff[pts_pkg::IDX_W-1:0]] <= new_delay_ff;
         ident_ff[count_ff[pts_pkg::IDX_W-1:0]] <= id_ff;
         level_ff[count_ff[pts_pkg::IDX_W-1:0]] <= prio_ff;
         rep_ff[count_ff[pts_pkg::IDX_W-1:0]]   <= new_rep_ff;
      end
   end

   assign rsp_found     = found_ff;
   assign rsp_chosen_id = chosen_ff;
   assign rsp_pending   = pending_ff;
   assign rsp_status    = rstat_ff;

endmodule

[design/priority_timer_task_selector.sv]
// Channel  Dir  Handshake            Fields
// req_     in   req_valid/req_ready  action, now_ms, task_id, task_priority, wait_ms, repeats
// rsp_     out  rsp_valid/rsp_ready  found, chosen_id, pending, status
//
// One request is worked on at a time; an add skips the table scan.
// Select, cancel and query scan the N tasks in the table (at most 16)
// one entry per cycle. On an empty table the scan is skipped, as for
// an add.
// Reset is synchronous and active high; it empties the table and drops rsp_valid.
// A response waits in the output register while rsp_ready is low; the next
// request is still taken and worked on, and its result is held until the
// output register is free.
module priority_timer_task_selector (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [pts_pkg::ACTION_W-1:0] req_action,
   input  logic [pts_pkg::TIME_W-1:0]   req_now_ms,
   input  logic [pts_pkg::ID_W-1:0]     req_task_id,
   input  logic [pts_pkg::LEVEL_W-1:0]  req_task_priority,
   input  logic [pts_pkg::TIME_W-1:0]   req_wait_ms,
   input  logic                         req_repeats,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic [pts_pkg::ID_W-1:0]     rsp_chosen_id,
   output logic                         rsp_pending,
   output logic                         rsp_status
);

   // The controller sequences each request: capture, scan the table one
   // entry per cycle (skipped for an add or an empty table), apply the table
   // update, then hand the result to the output register.
   pts_pkg::pts_cmd_type  cmd;
   pts_pkg::pts_stat_type stat;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the task table in insertion order and the search
   // trackers. A select keeps the first entry of the highest level above
   // timer level, or else the oldest entry with the earliest due time that
   // has already passed. Removing an entry moves every later entry up one
   // place.
   pts_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_now_ms        (req_now_ms),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_wait_ms       (req_wait_ms),
      .req_repeats       (req_repeats),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_found         (rsp_found),
      .rsp_chosen_id     (rsp_chosen_id),
      .rsp_pending       (rsp_pending),
      .rsp_status        (rsp_status)
   );

endmodule

[design/pts_checker.sv]
module pts_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [pts_pkg::ACTION_W-1:0] req_action,
   input logic [pts_pkg::TIME_W-1:0]   req_now_ms,
   input logic [pts_pkg::ID_W-1:0]     req_task_id,
   input logic [pts_pkg::LEVEL_W-1:0]  req_task_priority,
   input logic [pts_pkg::TIME_W-1:0]   req_wait_ms,
   input logic                         req_repeats,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_found,
   input logic [pts_pkg::ID_W-1:0]     rsp_chosen_id,
   input logic                         rsp_pending,
   input logic                         rsp_status
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] open_ff;
   logic [1:0] open_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Requests taken whose response has not yet been transferred.
   always_comb begin
      open_in = open_ff;
      if (req_xfer && !rsp_xfer) begin
         open_in = open_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_found, rsp_chosen_id, rsp_pending, rsp_status}))
      else $error("response changed while stalled");

   // Every response answers a request that was taken earlier.
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (open_ff != 2'd0))
      else $error("response without an outstanding request");

   // One request at a time: the block is busy right after a transfer.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request taken while the previous one is in work");

   // A refused add reports nothing else.
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_found && !rsp_pending && (rsp_chosen_id == '0))
      else $error("full-table status mixed with other results");

   // A query answer reports nothing else.
   a_pending_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pending |-> !rsp_found && !rsp_status && (rsp_chosen_id == '0))
      else $error("pending flag mixed with other results");

endmodule

bind priority_timer_task_selector pts_checker u_pts_checker (.*);
